### src/osb_pkg.sv
package osb_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int MAX_OUT     = 16;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CMP_W = (IDX_W > 4) ? IDX_W : 4;
  localparam int REP_W = $clog2(MAX_OUT + 1);

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_START = 2'd1,
    REQ_TICK  = 2'd2
  } req_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_FLUSH
  } state_e;

  // One timer slot as it travels around the ring.
  typedef struct packed {
    logic                   active;
    logic [COUNT_WIDTH-1:0] count;
    logic [COUNT_WIDTH-1:0] reload;
    logic [7:0]             row;
    logic [7:0]             column;
  } slot_rec_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [15:0] reload_ticks;
    logic [7:0]  key_row;
    logic [7:0]  key_column;
  } req_t;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] column;
    logic [3:0] slot;
  } timeout_t;

  function automatic logic [COUNT_WIDTH-1:0] to_count(input logic [15:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[COUNT_WIDTH-1:0];
  endfunction

endpackage

### src/osb_cell.sv
module osb_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_en_i,
  input  osb_pkg::slot_rec_t   rec_i,
  output osb_pkg::slot_rec_t   rec_o
);

  osb_pkg::slot_rec_t rec_q, rec_d;

  assign rec_d = shift_en_i ? rec_i : rec_q;
  assign rec_o = rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

endmodule

### src/osb_ctrl.sv
module osb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  osb_pkg::req_t       req_i,
  input  osb_pkg::slot_rec_t  head_i,
  output osb_pkg::slot_rec_t  head_o,
  output logic                shift_en_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output osb_pkg::timeout_t   out_o,
  output logic                out_last_o
);

  osb_pkg::state_e                state_q, state_d;
  osb_pkg::req_t                  req_q, req_d;
  logic [osb_pkg::IDX_W-1:0]      cnt_q, cnt_d;
  logic [osb_pkg::REP_W-1:0]      rep_q, rep_d;
  logic                           pend_valid_q, pend_valid_d;
  osb_pkg::timeout_t              pend_q, pend_d;
  logic                           m_valid_q, m_valid_d;
  osb_pkg::timeout_t              out_q, out_d;
  logic                           last_q, last_d;

  logic                           match;
  logic                           expire;
  logic                           report;
  logic                           out_free;
  logic                           stall;
  logic [osb_pkg::CMP_W-1:0]      cnt_ext;
  osb_pkg::timeout_t              new_to;

  assign cnt_ext  = osb_pkg::CMP_W'(cnt_q);
  assign match    = (osb_pkg::CMP_W'(req_q.slot) == cnt_ext);
  assign out_free = !m_valid_q || m_axis_tready;

  // Head record update for the current request.
  always_comb begin
    head_o = head_i;
    expire = 1'b0;
    case (req_q.kind)
      osb_pkg::REQ_INIT: begin
        if (match) begin
          head_o.reload = osb_pkg::to_count(req_q.reload_ticks);
          head_o.row    = req_q.key_row;
          head_o.column = req_q.key_column;
          head_o.count  = '0;
          head_o.active = 1'b0;
        end
      end
      osb_pkg::REQ_START: begin
        if (match) begin
          head_o.count  = head_i.reload;
          head_o.active = 1'b1;
        end
      end
      osb_pkg::REQ_TICK: begin
        if (head_i.active) begin
          if (head_i.count <= osb_pkg::COUNT_WIDTH'(1)) begin
            head_o.count  = '0;
            head_o.active = 1'b0;
            expire        = 1'b1;
          end else begin
            head_o.count = head_i.count - osb_pkg::COUNT_WIDTH'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign new_to.row    = head_i.row;
  assign new_to.column = head_i.column;
  assign new_to.slot   = cnt_ext[3:0];

  assign report     = (state_q == osb_pkg::ST_PASS) && expire &&
                      (rep_q < osb_pkg::REP_W'(osb_pkg::MAX_OUT));
  assign stall      = report && pend_valid_q && !out_free;
  assign shift_en_o = (state_q == osb_pkg::ST_PASS) && !stall;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    cnt_d        = cnt_q;
    rep_d        = rep_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    out_d        = out_q;
    last_d       = last_q;
    s_axis_tready = 1'b0;

    case (state_q)
      osb_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          req_d   = req_i;
          cnt_d   = '0;
          rep_d   = '0;
          state_d = osb_pkg::ST_PASS;
        end
      end
      osb_pkg::ST_PASS: begin
        if (shift_en_o) begin
          if (report) begin
            if (pend_valid_q) begin
              m_valid_d = 1'b1;
              out_d     = pend_q;
              last_d    = 1'b0;
            end
            pend_d       = new_to;
            pend_valid_d = 1'b1;
            rep_d        = rep_q + osb_pkg::REP_W'(1);
          end
          if (cnt_q == osb_pkg::IDX_W'(osb_pkg::NUM_SLOTS - 1)) begin
            state_d = pend_valid_d ? osb_pkg::ST_FLUSH : osb_pkg::ST_IDLE;
          end else begin
            cnt_d = cnt_q + osb_pkg::IDX_W'(1);
          end
        end
      end
      osb_pkg::ST_FLUSH: begin
        if (out_free) begin
          m_valid_d    = 1'b1;
          out_d        = pend_q;
          last_d       = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = osb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = osb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= osb_pkg::ST_IDLE;
      cnt_q        <= '0;
      rep_q        <= '0;
      pend_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      rep_q        <= rep_d;
      pend_valid_q <= pend_valid_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pend_q <= pend_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign out_o         = out_q;
  assign out_last_o    = last_q;

endmodule

### src/one_shot_timer_bank.sv
// Bank of one-shot timers tagged with a key matrix row and column. Send a
// request on the slave stream with its kind in tuser: init stores a slot's
// reload count and tags and idles the slot, start (re)loads the count from
// the reload and arms the slot, tick counts every armed slot down by one.
// Every request is taken in the idle state and then makes one step per slot
// before the earliest next transfer, since the slot records sit in a ring of
// cells that rotates one position per cycle unless stalled, and the request
// touches each slot once as it passes the head cell. A tick that expires
// slots then flushes its final timeout, and back-pressure on the master
// stream can hold the ring. Timeouts leave in ascending slot order, at most
// MAX_OUT per tick, with tlast on the final one. Init and start give no
// output.
module one_shot_timer_bank (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, low bit up: slot[3:0], reload_ticks[15:0], key_row[7:0],
  // key_column[7:0], zero fill[3:0]
  input  logic [39:0] s_axis_tdata,
  // tuser: req_type[1:0] (init, start, tick)
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, low bit up: out_row[7:0], out_column[7:0], out_slot[3:0],
  // zero fill[3:0]
  output logic [23:0] m_axis_tdata,
  // tlast: last timeout of this tick
  output logic        m_axis_tlast
);

  osb_pkg::req_t      req;
  osb_pkg::slot_rec_t rec [osb_pkg::NUM_SLOTS];
  osb_pkg::slot_rec_t head_new;
  logic               shift_en;
  osb_pkg::timeout_t  out_item;

  // Unpack the request fields.
  assign req.kind         = s_axis_tuser;
  assign req.slot         = s_axis_tdata[3:0];
  assign req.reload_ticks = s_axis_tdata[19:4];
  assign req.key_row      = s_axis_tdata[27:20];
  assign req.key_column   = s_axis_tdata[35:28];

  // Ring of slot cells: each cell takes its upper neighbor, the top cell
  // takes the updated head record, so slot k sits at the head on step k.
  for (genvar i = 0; i < osb_pkg::NUM_SLOTS; i++) begin : g_cell
    osb_pkg::slot_rec_t nxt;
    if (i == osb_pkg::NUM_SLOTS - 1) begin : g_top
      assign nxt = head_new;
    end else begin : g_mid
      assign nxt = rec[i+1];
    end
    osb_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (shift_en),
      .rec_i      (nxt),
      .rec_o      (rec[i])
    );
  end

  // Sequencer: steps the ring, updates the head and queues timeouts.
  osb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .req_i         (req),
    .head_i        (rec[0]),
    .head_o        (head_new),
    .shift_en_o    (shift_en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .out_o         (out_item),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_item.slot, out_item.column, out_item.row};

endmodule
